FILE: rtl/core/temp_fan_autotune_macros.svh
// Assertion helpers for the fan regulation block.
// Each macro expects clk and rst_n in scope.
`ifndef TEMP_FAN_AUTOTUNE_MACROS_SVH
`define TEMP_FAN_AUTOTUNE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("temp_fan_autotune: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("temp_fan_autotune: next-cycle check failed");

`endif

FILE: rtl/core/tfa_pkg.sv
`default_nettype none

package tfa_pkg;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_TARGET_TEMP   = 3'd0,
    CFG_OVERHEAT_TEMP = 3'd1,
    CFG_HYSTERESIS    = 3'd2,
    CFG_FAN_TOP       = 3'd3,
    CFG_FAN_BOTTOM    = 3'd4,
    CFG_PWM_MIN       = 3'd5,
    CFG_PWM_MAX       = 3'd6
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Field widths.
  localparam int unsigned TEMP_W = 9;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned PWM_W  = 8;

  // Reset values of the configuration registers.
  localparam logic [7:0] RST_TARGET_TEMP   = 8'd80;
  localparam logic [7:0] RST_OVERHEAT_TEMP = 8'd90;
  localparam logic [5:0] RST_HYSTERESIS    = 6'd3;
  localparam logic [6:0] RST_FAN_TOP       = 7'd100;
  localparam logic [6:0] RST_FAN_BOTTOM    = 7'd0;
  localparam logic [7:0] RST_PWM_MIN       = 8'd0;
  localparam logic [7:0] RST_PWM_MAX       = 8'd255;

  // Fan percent limits and regulation steps.
  localparam logic [6:0] PCT_FULL   = 7'd100;
  localparam logic [3:0] STEP_LARGE = 4'd10;
  localparam logic [3:0] STEP_SMALL = 4'd5;

  // Divide by 5: multiply by 205 and drop 10 bits, exact for values up to 511.
  localparam logic [7:0] RECIP5       = 8'd205;
  localparam int unsigned RECIP5_SHIFT = 10;

  // Divide by 100: multiply by 5243 and drop 19 bits, exact below 2**15.
  localparam logic [12:0] RECIP100       = 13'd5243;
  localparam int unsigned RECIP100_SHIFT  = 19;
  // Rounding term 50 already scaled by the reciprocal.
  localparam logic [27:0] PWM_ROUND_SCALED = 28'd262150;

endpackage

`default_nettype wire

FILE: rtl/core/tfa_in_if.sv
`default_nettype none

interface tfa_in_if
  import tfa_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tfa_out_if.sv
`default_nettype none

interface tfa_out_if
  import tfa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] fan_percent;
  logic [PWM_W-1:0] pwm_code;
  logic             fan_changed;
  logic             fan_in_window;
  logic             fan_optimal;
  logic             overheat;

  modport source (output valid, output fan_percent, output pwm_code, output fan_changed,
                  output fan_in_window, output fan_optimal, output overheat, input ready);
  modport sink   (input valid, input fan_percent, input pwm_code, input fan_changed,
                  input fan_in_window, input fan_optimal, input overheat, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/temp_fan_autotune.sv
// Channel   Dir  Beat contents
// in_ch     in   temperature (9-bit signed degrees)
// out_ch    out  fan_percent, pwm_code, fan_changed, fan_in_window, fan_optimal, overheat
// cfg_*     in   write enable, register index, 8-bit write data
//
// One beat in gives one beat out, through the sample register and the result register.
// A new sample can be taken every cycle while the result is not stalled; the fan
// percent feedback closes between the sample register and the result register.
// Synchronous active-low reset restores the register defaults, fan at 0 percent
// and previous temperature at 0 degrees.
// A stalled result holds in the result register; the sample register keeps
// accepting until it too is full.
`default_nettype none
`include "temp_fan_autotune_macros.svh"

module temp_fan_autotune
  import tfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tfa_in_if.sink                     in_ch,
  tfa_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [7:0] tgt_r, ovh_r, pmin_r, pmax_r;
  logic [5:0] hys_r;
  logic [6:0] top_r, bot_r;
  logic [20:0] range_k_r;

  // Sample stage.
  logic                     in_v_r;
  logic signed [TEMP_W-1:0] in_temp_r, in_last_r, last_temp_r;
  logic signed [TEMP_W:0]   in_tdiff_r;
  logic signed [7:0]        in_q5_r;

  // Regulation state and result stage.
  logic [PCT_W-1:0] fan_r;
  logic             out_v_r;
  logic [PCT_W-1:0] out_pct_r;
  logic [PWM_W-1:0] out_pwm_r;
  logic             out_chg_r, out_win_r, out_opt_r, out_hot_r;

  logic accept, adv;

  // Handshake: the result register frees the sample register when it moves.
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= RST_TARGET_TEMP;
      ovh_r  <= RST_OVERHEAT_TEMP;
      hys_r  <= RST_HYSTERESIS;
      top_r  <= RST_FAN_TOP;
      bot_r  <= RST_FAN_BOTTOM;
      pmin_r <= RST_PWM_MIN;
      pmax_r <= RST_PWM_MAX;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_TARGET_TEMP:   tgt_r  <= cfg_wdata;
        CFG_OVERHEAT_TEMP: ovh_r  <= cfg_wdata;
        CFG_HYSTERESIS:    hys_r  <= cfg_wdata[5:0];
        CFG_FAN_TOP:       top_r  <= cfg_wdata[6:0];
        CFG_FAN_BOTTOM:    bot_r  <= cfg_wdata[6:0];
        CFG_PWM_MIN:       pmin_r <= cfg_wdata;
        CFG_PWM_MAX:       pmax_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // PWM span premultiplied by the 1/100 reciprocal; reversed bounds give zero span.
  logic [7:0]  range_c;
  logic [20:0] range_k_nxt;
  always_comb begin
    range_c     = (pmax_r >= pmin_r) ? (pmax_r - pmin_r) : 8'd0;
    range_k_nxt = 21'(range_c * RECIP100);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_k_r <= 21'(RST_PWM_MAX * RECIP100);
    end else begin
      range_k_r <= range_k_nxt;
    end
  end

  // Temperature swing and its truncated fifth, taken when the sample arrives.
  logic signed [TEMP_W:0] tdiff_c;
  logic [TEMP_W:0]        tdiff_abs_c;
  logic [16:0]            q5_prod_c;
  logic [6:0]             q5_mag_c;
  logic signed [7:0]      q5_c;
  always_comb begin
    tdiff_c     = {in_ch.temperature[TEMP_W-1], in_ch.temperature}
                - {last_temp_r[TEMP_W-1], last_temp_r};
    tdiff_abs_c = tdiff_c[TEMP_W] ? (~tdiff_c + 1'b1) : tdiff_c;
    q5_prod_c   = tdiff_abs_c[TEMP_W-1:0] * RECIP5;
    q5_mag_c    = q5_prod_c[RECIP5_SHIFT +: 7];
    q5_c        = tdiff_c[TEMP_W] ? -$signed({1'b0, q5_mag_c}) : $signed({1'b0, q5_mag_c});
  end

  // Sample register; the previous temperature follows accepted samples.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      last_temp_r <= '0;
    end else begin
      if (accept) begin
        in_v_r      <= 1'b1;
        last_temp_r <= in_ch.temperature;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_temp_r  <= in_ch.temperature;
      in_last_r  <= last_temp_r;
      in_tdiff_r <= tdiff_c;
      in_q5_r    <= q5_c;
    end
  end

  // Regulation rules, tried in order, on 12-bit signed values.
  logic signed [11:0] t_s, l_s, d_s, q_s, old_s, tgt_s, hys_s, top_s, bot_s, ovh_s;
  logic signed [11:0] np_raw, np_top;
  logic [PCT_W-1:0]   np_c;
  logic               hot_c, win_c, chg_c, opt_c;
  always_comb begin
    t_s   = {{(12-TEMP_W){in_temp_r[TEMP_W-1]}}, in_temp_r};
    l_s   = {{(12-TEMP_W){in_last_r[TEMP_W-1]}}, in_last_r};
    d_s   = {{(11-TEMP_W){in_tdiff_r[TEMP_W]}}, in_tdiff_r};
    q_s   = {{4{in_q5_r[7]}}, in_q5_r};
    old_s = {5'd0, fan_r};
    tgt_s = {4'd0, tgt_r};
    hys_s = {6'd0, hys_r};
    top_s = {5'd0, top_r};
    bot_s = {5'd0, bot_r};
    ovh_s = {4'd0, ovh_r};
    hot_c  = 1'b0;
    np_raw = old_s;
    np_top = (t_s > tgt_s + hys_s) ? old_s + 12'sd10 : old_s + 12'sd5;

    if (t_s > ovh_s && fan_r < PCT_FULL) begin
      // Overheat forces full speed.
      np_raw = {5'd0, PCT_FULL};
      hot_c  = 1'b1;
    end else if (t_s > tgt_s && old_s < top_s && !d_s[11]) begin
      // Above target and not cooling: step up, capped at the top limit.
      np_raw = (np_top > top_s) ? top_s : np_top;
    end else if (old_s > bot_s && t_s < tgt_s - hys_s) begin
      // Well below target: back off, or follow a large rise.
      if (d_s <= 12'sd0) begin
        np_raw = old_s - 12'sd1 + q_s;
      end else if (d_s >= 12'sd5) begin
        np_raw = old_s + q_s;
      end
    end else begin
      // All other cases, such as inside the band: track the drift degree for degree.
      if (old_s > bot_s && d_s < 12'sd0 && l_s < tgt_s) begin
        np_raw = old_s + d_s;
      end else if (old_s < top_s && d_s > 12'sd0 && t_s > tgt_s - hys_s) begin
        np_raw = old_s + d_s;
      end
    end

    // Clamp to 0..100.
    if (np_raw > 12'sd100) begin
      np_c = PCT_FULL;
    end else if (np_raw < 12'sd0) begin
      np_c = '0;
    end else begin
      np_c = np_raw[PCT_W-1:0];
    end

    win_c = np_c <= top_r;
    chg_c = np_c != fan_r;
    opt_c = !chg_c || (np_c < fan_r && win_c);
  end

  // PWM code: floor((p*span + 50) / 100) + pwm_min.
  logic [27:0] pwm_prod_c;
  logic [PWM_W-1:0] pwm_c;
  always_comb begin
    pwm_prod_c = 28'(np_c * range_k_r) + PWM_ROUND_SCALED;
    pwm_c      = PWM_W'(pwm_prod_c[RECIP100_SHIFT +: PWM_W] + pmin_r);
  end

  // Fan state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fan_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (adv) begin
        fan_r   <= np_c;
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pct_r <= np_c;
      out_pwm_r <= pwm_c;
      out_chg_r <= chg_c;
      out_win_r <= win_c;
      out_opt_r <= opt_c;
      out_hot_r <= hot_c;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.fan_percent   = out_pct_r;
  assign out_ch.pwm_code      = out_pwm_r;
  assign out_ch.fan_changed   = out_chg_r;
  assign out_ch.fan_in_window = out_win_r;
  assign out_ch.fan_optimal   = out_opt_r;
  assign out_ch.overheat      = out_hot_r;

  // Fan state never leaves the 0..100 range.
  `TFA_ASSERT_NOW(a_fan_range, 1'b1, fan_r <= PCT_FULL)
  // A shown result always matches the fan state it produced.
  `TFA_ASSERT_NOW(a_state_match, out_v_r, fan_r == out_pct_r)
  // An overheat result always drives the fan to full.
  `TFA_ASSERT_NOW(a_hot_full, out_v_r && out_hot_r, out_pct_r == PCT_FULL)
  // A sample that moves on is shown in the next cycle.
  `TFA_ASSERT_NEXT(a_adv_shows, adv, out_v_r)

endmodule

`default_nettype wire
